/* hdl/blg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package blg_pkg;

    // history depth, 2..16
    localparam int unsigned WINDOW     = 5;

    localparam int unsigned VOLT_W     = 12;
    localparam int unsigned PCT_W      = 7;
    // widest segment span is 33 percent, so every quotient stays below 64
    localparam int unsigned SPAN_W     = 6;
    localparam int unsigned QUO_W      = SPAN_W;
    localparam int unsigned DEN_W      = VOLT_W;
    localparam int unsigned NUM_W      = DEN_W + QUO_W;
    localparam int unsigned SUM_W      = $clog2(WINDOW * 100 + 1);
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    localparam int unsigned MCNT_W     = $clog2(SPAN_W);
    localparam int unsigned DCNT_W     = $clog2(QUO_W);
    localparam int unsigned HCNT_W     = $clog2(WINDOW);

    localparam logic [MCNT_W-1:0] MUL_LAST  = MCNT_W'(SPAN_W - 1);
    localparam logic [DCNT_W-1:0] DIV_LAST  = DCNT_W'(QUO_W - 1);
    localparam logic [HCNT_W-1:0] HIST_LAST = HCNT_W'(WINDOW - 1);

    // floor(floor(sum / WINDOW) / 5) is floor(sum / (WINDOW * 5))
    localparam logic [DEN_W-1:0] AVG_DIV = DEN_W'(WINDOW * 5);

    localparam logic [VOLT_W-1:0] KNEE_FULL_RST    = 12'd2477;
    localparam logic [VOLT_W-1:0] KNEE_TQ_RST      = 12'd2400;
    localparam logic [VOLT_W-1:0] KNEE_HALF_RST    = 12'd2325;
    localparam logic [VOLT_W-1:0] KNEE_QUARTER_RST = 12'd2223;
    localparam logic [VOLT_W-1:0] KNEE_EMPTY_RST   = 12'd2146;

    localparam logic [VOLT_W-1:0] ALT_KNEE_FULL = 12'd2477;
    localparam logic [VOLT_W-1:0] ALT_KNEE_HIGH = 12'd2325;
    localparam logic [VOLT_W-1:0] ALT_KNEE_MID  = 12'd2223;
    localparam logic [VOLT_W-1:0] ALT_KNEE_LOW  = 12'd2146;

    localparam logic [PCT_W-1:0] PCT_FULL     = 7'd100;
    localparam logic [PCT_W-1:0] PCT_TQ       = 7'd75;
    localparam logic [PCT_W-1:0] PCT_HALF     = 7'd50;
    localparam logic [PCT_W-1:0] PCT_QUARTER  = 7'd25;
    localparam logic [PCT_W-1:0] PCT_EMPTY    = 7'd5;
    localparam logic [PCT_W-1:0] PCT_ALT_HIGH = 7'd68;
    localparam logic [PCT_W-1:0] PCT_ALT_MID  = 7'd35;
    localparam logic [PCT_W-1:0] PCT_ZERO     = 7'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROFILE      = 3'd0,
        CFG_KNEE_FULL    = 3'd1,
        CFG_KNEE_TQ      = 3'd2,
        CFG_KNEE_HALF    = 3'd3,
        CFG_KNEE_QUARTER = 3'd4,
        CFG_KNEE_EMPTY   = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_MUL,
        ST_DIV,
        ST_PUSH,
        ST_SUM,
        ST_AVG,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [SPAN_W-1:0] a;
        logic [DEN_W-1:0]  b;
    } t_mul_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
        logic             rem_nz;
    } t_div_rsp;

    typedef struct packed {
        logic             push;
        logic [PCT_W-1:0] pct;
    } t_hist_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] sum;
    } t_hist_rsp;

endpackage

`default_nettype wire

/* hdl/blg_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface blg_in_if;
    logic                       valid;
    logic                       ready;
    logic [blg_pkg::VOLT_W-1:0] voltage;

    modport source (output valid, output voltage, input ready);
    modport sink   (input valid, input voltage, output ready);
endinterface

interface blg_out_if;
    logic                      valid;
    logic                      ready;
    logic [blg_pkg::PCT_W-1:0] level;
    logic [blg_pkg::PCT_W-1:0] instant_level;

    modport source (output valid, output level, output instant_level, input ready);
    modport sink   (input valid, input level, input instant_level, output ready);
endinterface

interface blg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [blg_pkg::CFG_IDX_W-1:0]  index;
    logic [blg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/battery_level_gauge.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | handshake     | payload
// ---------+-----+---------------+------------------------------------------
// i_in     | in  | valid / ready | voltage (12 bit, 0.01 V)
// o_out    | out | valid / ready | level (7 bit), instant_level (7 bit)
// i_cfg    | in  | valid / ready | index (3 bit), data (12 bit)
//
// one item at a time; a sample above the top knee or at or below the bottom
// knee gives 100 or 0 percent straight away, any other is interpolated.
// the work falls to the 6-step bit-serial multiplier, the 6-step
// bit-serial divider (used once for the segment and once for the average)
// and a sweep over the whole history.
// i_rst_n is synchronous and active low; the knees return to their defaults.
// the result waits in an output register; a stall on o_out holds only the
// last step, and i_cfg is always ready.

module battery_level_gauge (
    input  wire         i_clk,
    input  wire         i_rst_n,
    blg_in_if.sink      i_in,
    blg_out_if.source   o_out,
    blg_cfg_if.sink     i_cfg
);

    blg_pkg::t_state r_state, n_state;

    logic                       r_profile;
    logic [blg_pkg::VOLT_W-1:0] r_knee_full, r_knee_tq, r_knee_half;
    logic [blg_pkg::VOLT_W-1:0] r_knee_quarter, r_knee_empty;

    logic [blg_pkg::VOLT_W-1:0] r_volt, n_volt;
    logic [blg_pkg::PCT_W-1:0]  r_hi, n_hi;
    logic [blg_pkg::DEN_W-1:0]  r_den, n_den;
    logic [blg_pkg::PCT_W-1:0]  r_inst, n_inst;
    logic                       r_out_valid, n_out_valid;
    logic [blg_pkg::PCT_W-1:0]  r_out_level, n_out_level;
    logic [blg_pkg::PCT_W-1:0]  r_out_inst, n_out_inst;

    logic                       sel_flat;
    logic [blg_pkg::PCT_W-1:0]  sel_pct;
    logic [blg_pkg::PCT_W-1:0]  sel_hi;
    logic [blg_pkg::PCT_W-1:0]  sel_lo_pct;
    logic [blg_pkg::VOLT_W-1:0] sel_up;
    logic [blg_pkg::VOLT_W-1:0] sel_low;
    logic [blg_pkg::SPAN_W-1:0] sel_span;
    logic [blg_pkg::DEN_W-1:0]  sel_d;
    logic [blg_pkg::DEN_W-1:0]  sel_s;

    blg_pkg::t_mul_req  mul_req;
    blg_pkg::t_mul_rsp  mul_rsp;
    blg_pkg::t_div_req  div_req;
    blg_pkg::t_div_rsp  div_rsp;
    blg_pkg::t_hist_req hist_req;
    blg_pkg::t_hist_rsp hist_rsp;

    blg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    blg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    blg_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (hist_req),
        .o_rsp   (hist_rsp)
    );

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_profile      <= 1'b0;
            r_knee_full    <= blg_pkg::KNEE_FULL_RST;
            r_knee_tq      <= blg_pkg::KNEE_TQ_RST;
            r_knee_half    <= blg_pkg::KNEE_HALF_RST;
            r_knee_quarter <= blg_pkg::KNEE_QUARTER_RST;
            r_knee_empty   <= blg_pkg::KNEE_EMPTY_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                blg_pkg::CFG_PROFILE:      r_profile      <= i_cfg.data[0];
                blg_pkg::CFG_KNEE_FULL:    r_knee_full    <= i_cfg.data;
                blg_pkg::CFG_KNEE_TQ:      r_knee_tq      <= i_cfg.data;
                blg_pkg::CFG_KNEE_HALF:    r_knee_half    <= i_cfg.data;
                blg_pkg::CFG_KNEE_QUARTER: r_knee_quarter <= i_cfg.data;
                blg_pkg::CFG_KNEE_EMPTY:   r_knee_empty   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // segment choice: first knee from the top that the sample lies above
    always_comb begin
        sel_flat   = 1'b1;
        sel_pct    = blg_pkg::PCT_ZERO;
        sel_hi     = blg_pkg::PCT_ZERO;
        sel_lo_pct = blg_pkg::PCT_ZERO;
        sel_up     = '0;
        sel_low    = '0;
        if (!r_profile) begin
            if (r_volt > r_knee_full) begin
                sel_pct = blg_pkg::PCT_FULL;
            end else if (r_volt > r_knee_tq) begin
                sel_flat   = 1'b0;
                sel_hi     = blg_pkg::PCT_FULL;
                sel_lo_pct = blg_pkg::PCT_TQ;
                sel_up     = r_knee_full;
                sel_low    = r_knee_tq;
            end else if (r_volt > r_knee_half) begin
                sel_flat   = 1'b0;
                sel_hi     = blg_pkg::PCT_TQ;
                sel_lo_pct = blg_pkg::PCT_HALF;
                sel_up     = r_knee_tq;
                sel_low    = r_knee_half;
            end else if (r_volt > r_knee_quarter) begin
                sel_flat   = 1'b0;
                sel_hi     = blg_pkg::PCT_HALF;
                sel_lo_pct = blg_pkg::PCT_QUARTER;
                sel_up     = r_knee_half;
                sel_low    = r_knee_quarter;
            end else if (r_volt > r_knee_empty) begin
                sel_flat   = 1'b0;
                sel_hi     = blg_pkg::PCT_QUARTER;
                sel_lo_pct = blg_pkg::PCT_EMPTY;
                sel_up     = r_knee_quarter;
                sel_low    = r_knee_empty;
            end
        end else begin
            if (r_volt > blg_pkg::ALT_KNEE_FULL) begin
                sel_pct = blg_pkg::PCT_FULL;
            end else if (r_volt > blg_pkg::ALT_KNEE_HIGH) begin
                sel_flat   = 1'b0;
                sel_hi     = blg_pkg::PCT_FULL;
                sel_lo_pct = blg_pkg::PCT_ALT_HIGH;
                sel_up     = blg_pkg::ALT_KNEE_FULL;
                sel_low    = blg_pkg::ALT_KNEE_HIGH;
            end else if (r_volt > blg_pkg::ALT_KNEE_MID) begin
                sel_flat   = 1'b0;
                sel_hi     = blg_pkg::PCT_ALT_HIGH;
                sel_lo_pct = blg_pkg::PCT_ALT_MID;
                sel_up     = blg_pkg::ALT_KNEE_HIGH;
                sel_low    = blg_pkg::ALT_KNEE_MID;
            end else if (r_volt > blg_pkg::ALT_KNEE_LOW) begin
                sel_flat   = 1'b0;
                sel_hi     = blg_pkg::PCT_ALT_MID;
                sel_lo_pct = blg_pkg::PCT_EMPTY;
                sel_up     = blg_pkg::ALT_KNEE_MID;
                sel_low    = blg_pkg::ALT_KNEE_LOW;
            end
        end
    end

    assign sel_span = blg_pkg::SPAN_W'(sel_hi - sel_lo_pct);
    assign sel_d    = sel_up - r_volt;
    assign sel_s    = sel_up - sel_low;

    // hi - ceil(span * d / s) equals floor((hi * s - span * d) / s)
    always_comb begin
        n_state     = r_state;
        n_volt      = r_volt;
        n_hi        = r_hi;
        n_den       = r_den;
        n_inst      = r_inst;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_level = r_out_level;
        n_out_inst  = r_out_inst;
        mul_req     = '{start: 1'b0, a: sel_span, b: sel_d};
        div_req     = '{start: 1'b0, num: mul_rsp.prod, den: r_den};
        hist_req    = '{push: 1'b0, pct: r_inst};
        case (r_state)
            blg_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_volt  = i_in.voltage;
                    n_state = blg_pkg::ST_SEL;
                end
            end
            blg_pkg::ST_SEL: begin
                if (sel_flat) begin
                    n_inst  = sel_pct;
                    n_state = blg_pkg::ST_PUSH;
                end else begin
                    mul_req.start = 1'b1;
                    n_hi          = sel_hi;
                    n_den         = sel_s;
                    n_state       = blg_pkg::ST_MUL;
                end
            end
            blg_pkg::ST_MUL: begin
                if (mul_rsp.done) begin
                    div_req.start = 1'b1;
                    n_state       = blg_pkg::ST_DIV;
                end
            end
            blg_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    n_inst  = r_hi - blg_pkg::PCT_W'(div_rsp.quo)
                              - blg_pkg::PCT_W'(div_rsp.rem_nz);
                    n_state = blg_pkg::ST_PUSH;
                end
            end
            blg_pkg::ST_PUSH: begin
                hist_req.push = 1'b1;
                n_state       = blg_pkg::ST_SUM;
            end
            blg_pkg::ST_SUM: begin
                if (hist_rsp.done) begin
                    div_req.start = 1'b1;
                    div_req.num   = blg_pkg::NUM_W'(hist_rsp.sum);
                    div_req.den   = blg_pkg::AVG_DIV;
                    n_state       = blg_pkg::ST_AVG;
                end
            end
            blg_pkg::ST_AVG: begin
                if (div_rsp.done) begin
                    n_state = blg_pkg::ST_OUT;
                end
            end
            blg_pkg::ST_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    // quotient times five
                    n_out_level = blg_pkg::PCT_W'({div_rsp.quo, 2'b00})
                                  + blg_pkg::PCT_W'(div_rsp.quo);
                    n_out_inst  = r_inst;
                    n_state     = blg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = blg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= blg_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_volt      <= n_volt;
        r_hi        <= n_hi;
        r_den       <= n_den;
        r_inst      <= n_inst;
        r_out_level <= n_out_level;
        r_out_inst  <= n_out_inst;
    end

    assign i_in.ready          = (r_state == blg_pkg::ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.level         = r_out_level;
    assign o_out.instant_level = r_out_inst;

endmodule

`default_nettype wire

/* hdl/blg_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

module blg_mul (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire blg_pkg::t_mul_req i_req,
    output blg_pkg::t_mul_rsp     o_rsp
);

    logic [blg_pkg::NUM_W-1:0]  r_acc, n_acc;
    logic [blg_pkg::NUM_W-1:0]  r_mcand, n_mcand;
    logic [blg_pkg::SPAN_W-1:0] r_mplier, n_mplier;
    logic [blg_pkg::MCNT_W-1:0] r_cnt, n_cnt;
    logic                       r_busy, n_busy;
    logic                       r_done, n_done;

    // shift-and-add, one multiplier bit per cycle, lsb first
    always_comb begin
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_done   = 1'b0;
        if (i_req.start) begin
            n_acc    = '0;
            n_mcand  = blg_pkg::NUM_W'(i_req.b);
            n_mplier = i_req.a;
            n_cnt    = '0;
            n_busy   = 1'b1;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand  = r_mcand << 1;
            n_mplier = r_mplier >> 1;
            n_cnt    = r_cnt + 1'b1;
            if (r_cnt == blg_pkg::MUL_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_cnt    <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

`default_nettype wire

/* hdl/blg_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module blg_div (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire blg_pkg::t_div_req i_req,
    output blg_pkg::t_div_rsp     o_rsp
);

    logic [blg_pkg::DEN_W-1:0]  r_rem, n_rem;
    logic [blg_pkg::QUO_W-1:0]  r_lo, n_lo;
    logic [blg_pkg::QUO_W-1:0]  r_quo, n_quo;
    logic [blg_pkg::DEN_W-1:0]  r_den, n_den;
    logic [blg_pkg::DCNT_W-1:0] r_cnt, n_cnt;
    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    logic [blg_pkg::DEN_W:0]    trial;
    logic                       fits;

    // restoring division, one quotient bit per cycle; the upper part of the
    // dividend is always below the divisor, so only QUO_W steps are needed
    assign trial = {r_rem, r_lo[blg_pkg::QUO_W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    always_comb begin
        n_rem  = r_rem;
        n_lo   = r_lo;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = i_req.num[blg_pkg::NUM_W-1:blg_pkg::QUO_W];
            n_lo   = i_req.num[blg_pkg::QUO_W-1:0];
            n_quo  = '0;
            n_den  = i_req.den;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (fits) begin
                n_rem = blg_pkg::DEN_W'(trial - {1'b0, r_den});
            end else begin
                n_rem = trial[blg_pkg::DEN_W-1:0];
            end
            n_lo  = r_lo << 1;
            n_quo = {r_quo[blg_pkg::QUO_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == blg_pkg::DIV_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_lo  <= n_lo;
        r_quo <= n_quo;
        r_den <= n_den;
        r_cnt <= n_cnt;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.quo    = r_quo;
    assign o_rsp.rem_nz = |r_rem;

endmodule

`default_nettype wire

/* hdl/blg_hist.sv */
`timescale 1ns / 1ps
`default_nettype none

module blg_hist (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire blg_pkg::t_hist_req i_req,
    output blg_pkg::t_hist_rsp     o_rsp
);

    logic [blg_pkg::PCT_W-1:0]  r_hist [blg_pkg::WINDOW];
    logic [blg_pkg::PCT_W-1:0]  n_hist [blg_pkg::WINDOW];
    logic                       r_primed, n_primed;
    logic [blg_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [blg_pkg::HCNT_W-1:0] r_cnt, n_cnt;
    logic                       r_busy, n_busy;
    logic                       r_done, n_done;

    // after a push the window rotates once round, adding one entry a cycle
    always_comb begin
        n_hist   = r_hist;
        n_primed = r_primed;
        n_sum    = r_sum;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_done   = 1'b0;
        if (i_req.push) begin
            // first item fills the whole window
            for (int i = 0; i < blg_pkg::WINDOW - 1; i++) begin
                n_hist[i] = r_primed ? r_hist[i + 1] : i_req.pct;
            end
            n_hist[blg_pkg::WINDOW - 1] = i_req.pct;
            n_primed = 1'b1;
            n_sum    = '0;
            n_cnt    = '0;
            n_busy   = 1'b1;
        end else if (r_busy) begin
            n_sum = r_sum + blg_pkg::SUM_W'(r_hist[0]);
            for (int i = 0; i < blg_pkg::WINDOW - 1; i++) begin
                n_hist[i] = r_hist[i + 1];
            end
            n_hist[blg_pkg::WINDOW - 1] = r_hist[0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == blg_pkg::HIST_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_primed <= n_primed;
            r_busy   <= n_busy;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hist <= n_hist;
        r_sum  <= n_sum;
        r_cnt  <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sum  = r_sum;

endmodule

`default_nettype wire

/* hdl/blg_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module blg_checker (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_in_valid,
    input wire                       i_in_ready,
    input wire                       i_out_valid,
    input wire                       i_out_ready,
    input wire [blg_pkg::PCT_W-1:0]  i_out_level,
    input wire [blg_pkg::PCT_W-1:0]  i_out_instant_level
);

    // one item in flight: no second item straight after an accepted one
    a_in_one_at_a_time: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready
    ) else $error("input taken again straight after an item");

    // reset leaves no result waiting
    a_reset_clears: assert property (
        @(posedge i_clk)
        !i_rst_n |=> !i_out_valid
    ) else $error("result valid straight after reset");

    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_level) && $stable(i_out_instant_level))
    ) else $error("stalled result changed");

    a_out_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_level <= 7'd100 && i_out_instant_level <= 7'd100)
    ) else $error("percent out of range");

endmodule

bind battery_level_gauge blg_checker u_blg_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in.valid),
    .i_in_ready          (i_in.ready),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_out_level         (o_out.level),
    .i_out_instant_level (o_out.instant_level)
);

`default_nettype wire

/* bench/battery_level_gauge_test.sv */
`timescale 1ns / 1ps

module battery_level_gauge_test;
    import blg_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned BLOCKS      = 12;
    localparam int unsigned BLOCK_ITEMS = 130;
    localparam int unsigned HOLD_CYCLES = 500;
    localparam int unsigned MAX_PRINTS  = 40;

    localparam logic PROFILE_TABLE = 1'b0;
    localparam logic PROFILE_FIXED = 1'b1;

    // register indexes past the end of the map, writes to them are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam bit ROW_WRITE  = 1'b1;
    localparam bit ROW_SAMPLE = 1'b0;
    localparam bit TYPED      = 1'b1;
    localparam bit PREDICTED  = 1'b0;

    typedef struct packed {
        logic [PCT_W-1:0] level;
        logic [PCT_W-1:0] instant;
    } t_reading;

    typedef struct packed {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  idx;
        logic [VOLT_W-1:0]     val;
        bit                    typed;
        logic [PCT_W-1:0]      level;
        logic [PCT_W-1:0]      instant;
    } t_row;

    logic clk;
    logic rst_n;

    blg_in_if  in_ch ();
    blg_out_if out_ch ();
    blg_cfg_if cfg_ch ();

    battery_level_gauge dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // gauge copy: configuration and smoothing history
    logic              gauge_profile;
    logic [VOLT_W-1:0] knee_full, knee_tq, knee_half, knee_quarter, knee_empty;
    logic [PCT_W-1:0]  hist [WINDOW];
    bit                hist_primed;

    t_reading pending_readings [$];

    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_req;
    bit          offering;
    bit          cfg_offering;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count == CYCLE_LIMIT) begin
                $display("** battery_level_gauge: FAILED **");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // floor of hi - span * d / s over one segment, upper knee down to lower
    function automatic int unsigned segment_pct(input int unsigned v, input int unsigned upper,
                                                input int unsigned lower, input int unsigned hi,
                                                input int unsigned lo);
        int unsigned s;
        int unsigned d;
        s = upper - lower;
        d = upper - v;
        if (s == 0)
            return hi;
        return (hi * s - (hi - lo) * d) / s;
    endfunction

    function automatic int unsigned charge_pct(input logic [VOLT_W-1:0] v);
        if (gauge_profile == PROFILE_TABLE) begin
            if (v > knee_full)
                return PCT_FULL;
            if (v > knee_tq)
                return segment_pct(v, knee_full, knee_tq, PCT_FULL, PCT_TQ);
            if (v > knee_half)
                return segment_pct(v, knee_tq, knee_half, PCT_TQ, PCT_HALF);
            if (v > knee_quarter)
                return segment_pct(v, knee_half, knee_quarter, PCT_HALF, PCT_QUARTER);
            if (v > knee_empty)
                return segment_pct(v, knee_quarter, knee_empty, PCT_QUARTER, PCT_EMPTY);
            return PCT_ZERO;
        end
        if (v > ALT_KNEE_FULL)
            return PCT_FULL;
        if (v > ALT_KNEE_HIGH)
            return segment_pct(v, ALT_KNEE_FULL, ALT_KNEE_HIGH, PCT_FULL, PCT_ALT_HIGH);
        if (v > ALT_KNEE_MID)
            return segment_pct(v, ALT_KNEE_HIGH, ALT_KNEE_MID, PCT_ALT_HIGH, PCT_ALT_MID);
        if (v > ALT_KNEE_LOW)
            return segment_pct(v, ALT_KNEE_MID, ALT_KNEE_LOW, PCT_ALT_MID, PCT_EMPTY);
        return PCT_ZERO;
    endfunction

    function automatic t_reading advance_gauge(input logic [VOLT_W-1:0] v);
        t_reading    r;
        int unsigned sum;
        int unsigned avg;
        r.instant = PCT_W'(charge_pct(v));
        // first sample after reset fills the whole window
        if (!hist_primed) begin
            for (int i = 0; i < WINDOW; i++)
                hist[i] = r.instant;
            hist_primed = 1'b1;
        end
        for (int i = 0; i < WINDOW - 1; i++)
            hist[i] = hist[i + 1];
        hist[WINDOW - 1] = r.instant;
        sum = 0;
        for (int i = 0; i < WINDOW; i++)
            sum += hist[i];
        avg = sum / WINDOW;
        r.level = PCT_W'(avg - avg % 5);
        return r;
    endfunction

    function automatic logic [VOLT_W-1:0] pick_voltage();
        int anchor;
        int v;
        case ($urandom_range(19))
            0, 1, 2: return VOLT_W'($urandom);
            3:       return $urandom_range(1) ? '1 : '0;
            default: begin
                if (gauge_profile == PROFILE_FIXED) begin
                    case ($urandom_range(3))
                        0:       anchor = ALT_KNEE_FULL;
                        1:       anchor = ALT_KNEE_HIGH;
                        2:       anchor = ALT_KNEE_MID;
                        default: anchor = ALT_KNEE_LOW;
                    endcase
                end else begin
                    case ($urandom_range(4))
                        0:       anchor = knee_full;
                        1:       anchor = knee_tq;
                        2:       anchor = knee_half;
                        3:       anchor = knee_quarter;
                        default: anchor = knee_empty;
                    endcase
                end
                v = anchor + int'($urandom_range(48)) - 24;
                if (v < 0)
                    v = 0;
                if (v > 4095)
                    v = 4095;
                return VOLT_W'(v);
            end
        endcase
    endfunction

    task automatic offer_sample(input logic [VOLT_W-1:0] v, input bit typed,
                                input t_reading typed_reading);
        t_reading r;
        while ($urandom_range(99) < send_idle_pct) begin
            if (offering) begin
                in_ch.valid <= 1'b0;
                offering = 1'b0;
            end
            @(posedge clk);
        end
        in_ch.voltage <= v;
        in_ch.valid   <= 1'b1;
        offering = 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        r = advance_gauge(v);
        pending_readings.push_back(typed ? typed_reading : r);
    endtask

    // stop offering and let every outstanding reading come back
    task automatic drain_samples();
        if (offering) begin
            in_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        cfg_offering = 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            CFG_PROFILE:      gauge_profile = val[0];
            CFG_KNEE_FULL:    knee_full     = val;
            CFG_KNEE_TQ:      knee_tq       = val;
            CFG_KNEE_HALF:    knee_half     = val;
            CFG_KNEE_QUARTER: knee_quarter  = val;
            CFG_KNEE_EMPTY:   knee_empty    = val;
            default: ;
        endcase
    endtask

    task automatic close_writes();
        if (cfg_offering) begin
            cfg_ch.valid <= 1'b0;
            cfg_offering = 1'b0;
        end
    endtask

    task automatic load_random_setting(input int unsigned blk);
        int          kv [5];
        int          step;
        logic        prof;
        prof = PROFILE_TABLE;
        case (blk % 6)
            0: begin
                kv[0] = KNEE_FULL_RST;
                kv[1] = KNEE_TQ_RST;
                kv[2] = KNEE_HALF_RST;
                kv[3] = KNEE_QUARTER_RST;
                kv[4] = KNEE_EMPTY_RST;
            end
            1: begin
                prof = PROFILE_FIXED;
                foreach (kv[i])
                    kv[i] = $urandom_range(4095);
            end
            2: begin
                kv[0] = $urandom_range(4095, 1000);
                for (int i = 1; i < 5; i++) begin
                    step = $urandom_range(400, 1);
                    kv[i] = (kv[i - 1] > step) ? kv[i - 1] - step : 0;
                end
            end
            3: begin
                // unordered knees, some segments can never be selected
                foreach (kv[i])
                    kv[i] = $urandom_range(4095);
            end
            4: begin
                foreach (kv[i])
                    kv[i] = (blk < 6) ? 0 : 4095;
            end
            default: begin
                // tightly packed knees give one- to three-step segments
                kv[0] = $urandom_range(4095, 2000);
                for (int i = 1; i < 5; i++)
                    kv[i] = kv[i - 1] - int'($urandom_range(3, 1));
            end
        endcase
        write_reg(CFG_PROFILE, {(CFG_DATA_W - 1)'($urandom), prof});
        write_reg(CFG_KNEE_FULL, CFG_DATA_W'(kv[0]));
        write_reg(CFG_KNEE_TQ, CFG_DATA_W'(kv[1]));
        write_reg(CFG_KNEE_HALF, CFG_DATA_W'(kv[2]));
        write_reg(CFG_KNEE_QUARTER, CFG_DATA_W'(kv[3]));
        write_reg(CFG_KNEE_EMPTY, CFG_DATA_W'(kv[4]));
        if ($urandom_range(1))
            write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_DATA_W'($urandom));
    endtask

    // receiver: random back-pressure, or a long hold-off when asked
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        t_reading want;
        forever begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_readings.size() == 0) begin
                    report_mismatch($sformatf("reading level %0d instant %0d with none pending",
                                              out_ch.level, out_ch.instant_level));
                end else begin
                    want = pending_readings.pop_front();
                    if (out_ch.level !== want.level)
                        report_mismatch($sformatf("level %0d, want %0d",
                                                  out_ch.level, want.level));
                    if (out_ch.instant_level !== want.instant)
                        report_mismatch($sformatf("instant_level %0d, want %0d",
                                                  out_ch.instant_level, want.instant));
                end
            end
        end
    end

    initial begin
        t_row dir_rows [$];
        mismatches    = 0;
        hold_req      = 0;
        offering      = 1'b0;
        cfg_offering  = 1'b0;
        send_idle_pct = 6;
        recv_idle_pct = 50;
        gauge_profile = PROFILE_TABLE;
        knee_full     = KNEE_FULL_RST;
        knee_tq       = KNEE_TQ_RST;
        knee_half     = KNEE_HALF_RST;
        knee_quarter  = KNEE_QUARTER_RST;
        knee_empty    = KNEE_EMPTY_RST;
        hist_primed   = 1'b0;
        foreach (hist[i])
            hist[i] = '0;

        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.voltage <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= CFG_PROFILE;
        cfg_ch.data   <= '0;

        dir_rows = '{
            // default knees: rails, knees hit exactly and one step inside
            '{ROW_SAMPLE, CFG_PROFILE, 12'd4095, TYPED, 7'd100, 7'd100},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd0, TYPED, 7'd80, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd2146, TYPED, 7'd60, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd2478, TYPED, 7'd60, 7'd100},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd2477, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd2147, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd2400, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd2325, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd2223, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd2440, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd2270, PREDICTED, 7'd0, 7'd0},
            // fixed table, profile data with every upper bit set
            '{ROW_WRITE, CFG_PROFILE, 12'hFFF, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd2477, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd2325, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd2223, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd2147, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd2146, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd2478, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd2300, PREDICTED, 7'd0, 7'd0},
            // only bit 0 of the profile write counts; spare indexes are dropped
            '{ROW_WRITE, CFG_PROFILE, 12'hFFE, PREDICTED, 7'd0, 7'd0},
            '{ROW_WRITE, CFG_SPARE_LO, 12'hABC, PREDICTED, 7'd0, 7'd0},
            '{ROW_WRITE, CFG_SPARE_HI, 12'h543, PREDICTED, 7'd0, 7'd0},
            '{ROW_WRITE, CFG_KNEE_FULL, 12'd0, PREDICTED, 7'd0, 7'd0},
            '{ROW_WRITE, CFG_KNEE_TQ, 12'd0, PREDICTED, 7'd0, 7'd0},
            '{ROW_WRITE, CFG_KNEE_HALF, 12'd0, PREDICTED, 7'd0, 7'd0},
            '{ROW_WRITE, CFG_KNEE_QUARTER, 12'd0, PREDICTED, 7'd0, 7'd0},
            '{ROW_WRITE, CFG_KNEE_EMPTY, 12'd0, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd0, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd1, PREDICTED, 7'd0, 7'd0},
            '{ROW_WRITE, CFG_KNEE_FULL, 12'd4095, PREDICTED, 7'd0, 7'd0},
            '{ROW_WRITE, CFG_KNEE_TQ, 12'd4095, PREDICTED, 7'd0, 7'd0},
            '{ROW_WRITE, CFG_KNEE_HALF, 12'd4095, PREDICTED, 7'd0, 7'd0},
            '{ROW_WRITE, CFG_KNEE_QUARTER, 12'd4095, PREDICTED, 7'd0, 7'd0},
            '{ROW_WRITE, CFG_KNEE_EMPTY, 12'd4095, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd4095, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd4094, PREDICTED, 7'd0, 7'd0},
            // knees out of order
            '{ROW_WRITE, CFG_KNEE_FULL, 12'd2000, PREDICTED, 7'd0, 7'd0},
            '{ROW_WRITE, CFG_KNEE_TQ, 12'd3000, PREDICTED, 7'd0, 7'd0},
            '{ROW_WRITE, CFG_KNEE_HALF, 12'd1000, PREDICTED, 7'd0, 7'd0},
            '{ROW_WRITE, CFG_KNEE_QUARTER, 12'd1500, PREDICTED, 7'd0, 7'd0},
            '{ROW_WRITE, CFG_KNEE_EMPTY, 12'd500, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd1500, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd800, PREDICTED, 7'd0, 7'd0},
            '{ROW_SAMPLE, CFG_PROFILE, 12'd2500, PREDICTED, 7'd0, 7'd0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_write) begin
                drain_samples();
                write_reg(dir_rows[r].idx, dir_rows[r].val);
            end else begin
                close_writes();
                offer_sample(dir_rows[r].val, dir_rows[r].typed,
                             '{dir_rows[r].level, dir_rows[r].instant});
            end
        end

        for (int unsigned blk = 0; blk < BLOCKS; blk++) begin
            drain_samples();
            case (blk / 4)
                0: begin
                    send_idle_pct = 6;
                    recv_idle_pct = 50;
                end
                1: begin
                    send_idle_pct = 50;
                    recv_idle_pct = 6;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            load_random_setting(blk);
            close_writes();
            // long stall on the result side while samples keep coming
            if (blk == 1)
                hold_req = HOLD_CYCLES;
            for (int unsigned n = 0; n < BLOCK_ITEMS; n++)
                offer_sample(pick_voltage(), PREDICTED, '0);
        end

        drain_samples();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("** battery_level_gauge: PASSED **");
        else
            $display("** battery_level_gauge: FAILED **");
        $finish;
    end

endmodule
